// ===== rtl/jds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jds_pkg
// Shared constants for the joystick dead zone, scaling and smoothing block.
// ----------------------------------------------------------------------------
package jds_pkg;

  // Default raw sample width of the ADC.
  localparam int SAMPLE_BITS_DEF = 12;

  // Width of every configuration register.
  localparam int CFG_W = 12;

  // Width of the register index on the configuration port.
  localparam int CFG_IDX_W = 2;

  // Width of the signed result values.
  localparam int OUT_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 2'd3;

  // Register reset values.
  localparam logic [CFG_W-1:0] CENTER_RST    = 12'd2048;
  localparam logic [CFG_W-1:0] DEAD_ZONE_RST = 12'd100;
  localparam logic [CFG_W-1:0] MAX_RANGE_RST = 12'd4095;

  // Divide by ten of the smoothing filter new = (3*scaled + 7*prev) / 10,
  // done as x * 838861 >> 23, which is exact for every x below 2^19.
  localparam int                      SMOOTH_RECIP_W = 20;
  localparam logic [SMOOTH_RECIP_W-1:0] SMOOTH_RECIP = 20'd838861;
  localparam int                      SMOOTH_SHIFT   = 23;

  // Saturation limits of the scaled value.
  localparam logic [OUT_W-1:0] POS_LIMIT = 16'h7FFF;
  localparam logic [OUT_W-1:0] NEG_LIMIT = 16'h8000;

endpackage : jds_pkg
`default_nettype wire

// ===== rtl/jds_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jds_div
  import jds_pkg::*;
#(
  parameter int NB = 27,
  parameter int DW = CFG_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NB-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NB-1:0]      quotient
);

  localparam int CW = $clog2(NB);

  logic [DW-1:0] rem_r;
  logic [NB-1:0] quo_r;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          ge;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    shifted = {rem_r, quo_r[NB-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = ~diff[DW+1];
  end

  // Load on start, then shift one dividend bit in per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && !start && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NB - 1);
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= divisor;
      end else if (run_r) begin
        rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        quo_r <= {quo_r[NB-2:0], ge};
        if (cnt_r == '0) begin
          run_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule : jds_div
`default_nettype wire

// ===== rtl/joystick_deadzone_scale_smooth.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_deadzone_scale_smooth
// Dead zone, scaling to signed 16 bits and per-axis smoothing of ADC samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one raw sample and its axis.
//   The block raises in_stall while a request is being worked on and takes a
//   new one only when idle. Each request yields exactly one result on the
//   output channel (out_valid / out_stall): the axis, the scaled value and
//   the new smoothed value of that axis.
//   A sample beyond the dead zone with a non-empty range passes through
//   the restoring divider of the scaling step, one quotient bit per cycle.
//   A sample inside the dead zone, or any sample with an empty range,
//   skips the divider. The divide by ten of the smoothing filter is a
//   reciprocal multiply.
//   The result sits in an output register, so a new request is accepted
//   while the previous result waits. If the receiver still stalls when the
//   next result is ready, the block holds that result and stays busy.
//   Configuration writes (cfg_valid / cfg_ready) are always taken and must
//   arrive only while the block is idle.
//   Reset restores the register defaults and clears both filter states.
// ----------------------------------------------------------------------------
module joystick_deadzone_scale_smooth
  import jds_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_axis,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  // Result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_axis_out,
  output logic signed [OUT_W-1:0]     out_scaled,
  output logic signed [OUT_W-1:0]     out_smoothed,
  // Configuration channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  // Magnitude width and divider dividend width.
  localparam int MB = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int NB = MB + 15;
  localparam int SW = 20;
  localparam int PW = SW + SMOOTH_RECIP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCALE_WAIT,
    S_SMOOTH_PREP,
    S_SMOOTH_WAIT,
    S_OUT
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0] center_x_r;
  logic [CFG_W-1:0] center_y_r;
  logic [CFG_W-1:0] dead_zone_r;
  logic [CFG_W-1:0] max_range_r;

  logic                   axis_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   neg_r;
  logic signed [OUT_W-1:0] scaled_r;
  logic signed [OUT_W-1:0] sm_r;
  logic signed [OUT_W-1:0] filt_r [2];
  logic [SW-1:0]          sm_mag_r;

  logic                   div_start_r;
  logic [NB-1:0]          div_dividend_r;
  logic [CFG_W-1:0]       div_divisor_r;
  logic                   div_done;
  logic [NB-1:0]          div_q;

  logic                   out_valid_r;
  logic                   out_axis_r;
  logic signed [OUT_W-1:0] out_scaled_r;
  logic signed [OUT_W-1:0] out_smoothed_r;
  logic                   out_load;

  // Scaling datapath: distance from center, dead zone and numerator.
  logic [MB-1:0]      s_ext;
  logic [MB-1:0]      c_ext;
  logic [MB-1:0]      dz_ext;
  logic signed [MB:0] dist_v;
  logic               dist_neg;
  logic               dist_le0;
  logic [MB-1:0]      mag;
  logic [MB-1:0]      beyond;
  logic               in_dz;
  logic [CFG_W:0]     span;
  logic               span_ok;
  logic [NB-1:0]      num;

  always_comb begin
    s_ext    = MB'(sample_r);
    c_ext    = MB'(axis_r ? center_y_r : center_x_r);
    dz_ext   = MB'(dead_zone_r);
    dist_v   = $signed({1'b0, s_ext}) - $signed({1'b0, c_ext});
    dist_neg = dist_v[MB];
    dist_le0 = dist_neg || (dist_v == '0);
    mag      = dist_neg ? MB'(-dist_v) : dist_v[MB-1:0];
    in_dz    = mag < dz_ext;
    beyond   = mag - dz_ext;
    span     = {1'b0, max_range_r} - {1'b0, dead_zone_r};
    span_ok  = ~span[CFG_W] && (span != '0);
    // Multiply by 32768 as a shift; by 32767 as shift minus one copy.
    if (dist_le0) begin
      num = {beyond, 15'b0};
    end else begin
      num = {beyond, 15'b0} - NB'(beyond);
    end
  end

  // Saturated scaled value from the quotient.
  logic [OUT_W-1:0] scale_res;

  always_comb begin
    if (neg_r) begin
      scale_res = (div_q > NB'(32768)) ? NEG_LIMIT : (16'd0 - div_q[OUT_W-1:0]);
    end else begin
      scale_res = (div_q > NB'(32767)) ? POS_LIMIT : div_q[OUT_W-1:0];
    end
  end

  // Smoothing datapath: 3*scaled + 7*prev and its magnitude.
  logic signed [SW-1:0] s20;
  logic signed [SW-1:0] p20;
  logic signed [SW-1:0] sum;
  logic [SW-1:0]        sum_mag;

  always_comb begin
    s20     = SW'(scaled_r);
    p20     = SW'(filt_r[axis_r]);
    sum     = (s20 <<< 1) + s20 + (p20 <<< 3) - p20;
    sum_mag = sum[SW-1] ? SW'(-sum) : sum;
  end

  // Magnitude divided by ten through the reciprocal multiply.
  logic [PW-1:0]    sm_prod;
  logic [OUT_W-1:0] sm_q;

  always_comb begin
    sm_prod = PW'(sm_mag_r) * PW'(SMOOTH_RECIP);
    sm_q    = sm_prod[SMOOTH_SHIFT +: OUT_W];
  end

  // Divider for the scaling step.
  jds_div #(
    .NB (NB),
    .DW (CFG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend_r),
    .divisor  (div_divisor_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Configuration registers; the port never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= CENTER_RST;
      center_y_r  <= CENTER_RST;
      dead_zone_r <= DEAD_ZONE_RST;
      max_range_r <= MAX_RANGE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:  center_x_r  <= cfg_data;
        REG_CENTER_Y:  center_y_r  <= cfg_data;
        REG_DEAD_ZONE: dead_zone_r <= cfg_data;
        REG_MAX_RANGE: max_range_r <= cfg_data;
        default:       center_x_r  <= center_x_r;
      endcase
    end
  end

  // A finished result moves to the output register once it is free.
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      filt_r[0]   <= '0;
      filt_r[1]   <= '0;
    end else begin
      div_start_r <= (state_r == S_PREP) && !in_dz && span_ok;
      out_valid_r <= out_load || (out_valid_r && out_stall);
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            axis_r   <= in_axis;
            sample_r <= in_sample;
            state_r  <= S_PREP;
          end
        end
        S_PREP: begin
          neg_r <= dist_le0;
          if (in_dz || !span_ok) begin
            scaled_r <= '0;
            state_r  <= S_SMOOTH_PREP;
          end else begin
            div_dividend_r <= num;
            div_divisor_r  <= span[CFG_W-1:0];
            state_r        <= S_SCALE_WAIT;
          end
        end
        S_SCALE_WAIT: begin
          if (div_done) begin
            scaled_r <= $signed(scale_res);
            state_r  <= S_SMOOTH_PREP;
          end
        end
        S_SMOOTH_PREP: begin
          neg_r    <= sum[SW-1];
          sm_mag_r <= sum_mag;
          state_r  <= S_SMOOTH_WAIT;
        end
        S_SMOOTH_WAIT: begin
          sm_r    <= neg_r ? $signed(16'd0 - sm_q) : $signed(sm_q);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_axis_r     <= axis_r;
            out_scaled_r   <= scaled_r;
            out_smoothed_r <= sm_r;
            filt_r[axis_r] <= sm_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_axis_out = out_axis_r;
  assign out_scaled   = out_scaled_r;
  assign out_smoothed = out_smoothed_r;

endmodule : joystick_deadzone_scale_smooth
`default_nettype wire
